// ----- hdl/tpae_pkg.sv -----
// Shared constants and types of the trapezoid profile angle evaluator.
package tpae_pkg;

  localparam int unsigned TIME_FRAC = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAG_W     = 62;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ACCEL  = 3'd5;

  localparam logic [MAG_W-1:0] MAG_CAP = '1;

  typedef struct packed {
    logic                    sat;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic signed [63:0]      val;
  } tpae_prod_t;

endpackage

// ----- hdl/tpae_mul_time.sv -----
// Three-stage rounded, saturating product of a magnitude and a Q16.16 time.
module tpae_mul_time (
  input  logic                   clk_i,
  input  logic [63:0]            m_i,
  input  logic                   neg_i,
  input  logic [31:0]            t_i,
  input  logic                   half_i,
  output tpae_pkg::tpae_prod_t   res_o
);

  localparam int unsigned SUM_W = 97;
  localparam int unsigned SH_W  = SUM_W - tpae_pkg::TIME_FRAC;

  logic [63:0]        ph_q, pl_q, ph_d, pl_d;
  logic               neg1_q, half1_q, neg2_q;
  logic [SUM_W-1:0]   sum_d;
  logic [SH_W-1:0]    sh_d, sh_q;
  logic               over_d;
  logic [tpae_pkg::MAG_W-1:0] mag_d;
  logic signed [63:0] val_d;
  tpae_pkg::tpae_prod_t res_d, res_q;

  assign ph_d = m_i[63:32] * t_i;
  assign pl_d = m_i[31:0] * t_i;

  always_ff @(posedge clk_i) begin
    ph_q    <= ph_d;
    pl_q    <= pl_d;
    neg1_q  <= neg_i;
    half1_q <= half_i;
  end

  always_comb begin
    sum_d = {1'b0, ph_q, 32'd0} + {33'd0, pl_q}
          + (half1_q ? (SUM_W'(1) << tpae_pkg::TIME_FRAC)
                     : (SUM_W'(1) << (tpae_pkg::TIME_FRAC - 1)));
    sh_d  = half1_q ? SH_W'(sum_d >> (tpae_pkg::TIME_FRAC + 1))
                    : SH_W'(sum_d >> tpae_pkg::TIME_FRAC);
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    neg2_q <= neg1_q;
  end

  always_comb begin
    over_d    = |sh_q[SH_W-1:tpae_pkg::MAG_W];
    mag_d     = over_d ? tpae_pkg::MAG_CAP : sh_q[tpae_pkg::MAG_W-1:0];
    val_d     = neg2_q ? -$signed({2'b00, mag_d}) : $signed({2'b00, mag_d});
    res_d.sat = over_d;
    res_d.neg = neg2_q;
    res_d.mag = mag_d;
    res_d.val = val_d;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- hdl/trapezoid_profile_angle_eval.sv -----
// Top level: trapezoidal motion profile angle evaluator for one axis.
//
//  channel   direction  handshake           word
//  command   in         start, busy         elapsed_i
//  result    out        done_o (strobe)     angle_o, saturated_o
//  config    in         cfg_we_i, cfg_idx_i cfg_data_i
//
// One word enters per cycle; each result appears on done_o after passing the
// input and phase time registers, two chained multiply units of three stages
// each, and the cruise sum, braking term and clamp registers.
// Reset clears the valid line and all configuration registers to zero.
// The receiver cannot stall, so busy stays low and nothing is ever held.
module trapezoid_profile_angle_eval (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    elapsed_i,
  output logic                           done_o,
  output logic signed [31:0]             angle_o,
  output logic                           saturated_o,
  input  logic                           cfg_we_i,
  input  logic [tpae_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);

  localparam int unsigned LAT  = 11;
  localparam int unsigned L1_D = 3;
  localparam int unsigned FL_D = 7;

  typedef struct packed {
    logic               sat_a;
    logic               sat_pq;
    logic               sat_v;
    logic signed [63:0] v_val;
  } side_t;

  typedef struct packed {
    logic lin_pos;
    logic t2_pos;
  } flags_t;

  function automatic logic [64:0] sat_cap(input logic signed [64:0] s);
    logic signed [64:0] cap;
    logic [64:0]        r;
    cap = $signed({3'b000, tpae_pkg::MAG_CAP});
    if (s > cap) begin
      r = {1'b1, cap[63:0]};
    end else if (s < -cap) begin
      r = {1'b1, 64'(-cap)};
    end else begin
      r = {1'b0, s[63:0]};
    end
    return r;
  endfunction

  logic signed [31:0] accel_q, velocity_q, target_q;
  logic [31:0]        accel_time_q, duration_q;
  logic               use_accel_q;
  logic               accept;
  logic [LAT-1:0]     vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q      <= '0;
      accel_time_q <= '0;
      velocity_q   <= '0;
      duration_q   <= '0;
      target_q     <= '0;
      use_accel_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpae_pkg::CFG_ACCEL:      accel_q      <= $signed(cfg_data_i);
        tpae_pkg::CFG_ACCEL_TIME: accel_time_q <= cfg_data_i;
        tpae_pkg::CFG_VELOCITY:   velocity_q   <= $signed(cfg_data_i);
        tpae_pkg::CFG_DURATION:   duration_q   <= cfg_data_i;
        tpae_pkg::CFG_TARGET:     target_q     <= $signed(cfg_data_i);
        tpae_pkg::CFG_USE_ACCEL:  use_accel_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  logic [31:0] accel_mag, vel_mag;
  assign accel_mag = accel_q[31] ? (~accel_q + 32'd1) : accel_q;
  assign vel_mag   = velocity_q[31] ? (~velocity_q + 32'd1) : velocity_q;

  // input register
  logic [31:0] t0_q;
  always_ff @(posedge clk_i) begin
    t0_q <= elapsed_i;
  end

  // phase times
  logic signed [34:0] t_s, ta_s, dur_s, lin_a, lin_b, lin_c, t2_a, t2_c;
  logic [31:0]        t1_d, tv_d, u2_d;
  logic               lin_pos_d, t2_pos_d;

  always_comb begin
    t_s       = $signed({3'b000, t0_q});
    ta_s      = $signed({3'b000, accel_time_q});
    dur_s     = $signed({3'b000, duration_q});
    lin_a     = t_s - ta_s;
    lin_b     = dur_s - (ta_s + ta_s);
    lin_c     = (lin_b < lin_a) ? lin_b : lin_a;
    t2_a      = t_s - (dur_s - ta_s);
    t2_c      = (ta_s < t2_a) ? ta_s : t2_a;
    t1_d      = (t0_q < accel_time_q) ? t0_q : accel_time_q;
    tv_d      = use_accel_q ? lin_c[31:0] : t0_q;
    lin_pos_d = use_accel_q ? (lin_c > 35'sd0) : 1'b1;
    t2_pos_d  = use_accel_q && (t2_c > 35'sd0);
    u2_d      = t2_c[31:0];
  end

  logic [31:0] t1_q, tv_q, u2_q;
  flags_t      flg_q [FL_D];
  logic [31:0] t1_dly_q [L1_D];
  logic [31:0] u2_dly_q [L1_D];

  always_ff @(posedge clk_i) begin
    t1_q             <= t1_d;
    tv_q             <= tv_d;
    u2_q             <= u2_d;
    flg_q[0].lin_pos <= lin_pos_d;
    flg_q[0].t2_pos  <= t2_pos_d;
    for (int i = 1; i < FL_D; i++) begin
      flg_q[i] <= flg_q[i-1];
    end
    t1_dly_q[0] <= t1_q;
    u2_dly_q[0] <= u2_q;
    for (int i = 1; i < L1_D; i++) begin
      t1_dly_q[i] <= t1_dly_q[i-1];
      u2_dly_q[i] <= u2_dly_q[i-1];
    end
  end

  // first products
  tpae_pkg::tpae_prod_t a1, v1, p1, q1, a2, p2, q2;

  tpae_mul_time u_mul_a1 (
    .clk_i (clk_i), .m_i ({32'd0, accel_mag}), .neg_i (accel_q[31]),
    .t_i (t1_q), .half_i (1'b0), .res_o (a1)
  );
  tpae_mul_time u_mul_v (
    .clk_i (clk_i), .m_i ({32'd0, vel_mag}), .neg_i (velocity_q[31]),
    .t_i (tv_q), .half_i (1'b0), .res_o (v1)
  );
  tpae_mul_time u_mul_p1 (
    .clk_i (clk_i), .m_i ({32'd0, accel_mag}), .neg_i (accel_q[31]),
    .t_i (accel_time_q), .half_i (1'b0), .res_o (p1)
  );
  tpae_mul_time u_mul_q1 (
    .clk_i (clk_i), .m_i ({32'd0, accel_mag}), .neg_i (accel_q[31]),
    .t_i (u2_q), .half_i (1'b0), .res_o (q1)
  );

  // second products
  tpae_mul_time u_mul_a2 (
    .clk_i (clk_i), .m_i ({2'b00, a1.mag}), .neg_i (a1.neg),
    .t_i (t1_dly_q[L1_D-1]), .half_i (1'b1), .res_o (a2)
  );
  tpae_mul_time u_mul_p2 (
    .clk_i (clk_i), .m_i ({2'b00, p1.mag}), .neg_i (p1.neg),
    .t_i (u2_dly_q[L1_D-1]), .half_i (1'b0), .res_o (p2)
  );
  tpae_mul_time u_mul_q2 (
    .clk_i (clk_i), .m_i ({2'b00, q1.mag}), .neg_i (q1.neg),
    .t_i (u2_dly_q[L1_D-1]), .half_i (1'b1), .res_o (q2)
  );

  side_t side_q [L1_D];
  always_ff @(posedge clk_i) begin
    side_q[0].sat_a  <= a1.sat;
    side_q[0].sat_pq <= p1.sat | q1.sat;
    side_q[0].sat_v  <= v1.sat;
    side_q[0].v_val  <= v1.val;
    for (int i = 1; i < L1_D; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // cruise sum and braking term
  side_t              sd;
  flags_t             fl;
  logic [64:0]        sum1_r, b_r;
  logic signed [63:0] b_d, rot1_d, v_term;
  logic               sat6_d;
  logic signed [63:0] rot1_q, b_q;
  logic               sat6_q;

  always_comb begin
    sd     = side_q[L1_D-1];
    fl     = flg_q[FL_D-1];
    v_term = fl.lin_pos ? sd.v_val : 64'sd0;
    sum1_r = sat_cap({a2.val[63], a2.val} + {v_term[63], v_term});
    b_r    = sat_cap({p2.val[63], p2.val} - {q2.val[63], q2.val});
    b_d    = $signed(b_r[63:0]);
    if (accel_q[31]) begin
      if (b_d > 64'sd0) b_d = 64'sd0;
    end else begin
      if (b_d < 64'sd0) b_d = 64'sd0;
    end
    if (!fl.t2_pos) b_d = 64'sd0;
    if (use_accel_q) begin
      rot1_d = $signed(sum1_r[63:0]);
      sat6_d = sd.sat_a | a2.sat | sum1_r[64] | (fl.lin_pos & sd.sat_v)
             | (fl.t2_pos & (sd.sat_pq | p2.sat | q2.sat | b_r[64]));
    end else begin
      rot1_d = sd.v_val;
      sat6_d = sd.sat_v;
    end
  end

  always_ff @(posedge clk_i) begin
    rot1_q <= rot1_d;
    b_q    <= b_d;
    sat6_q <= sat6_d;
  end

  // add braking term
  logic [64:0]        rot2_r;
  logic signed [63:0] rot2_q;
  logic               sat7_q;

  assign rot2_r = sat_cap({rot1_q[63], rot1_q} + {b_q[63], b_q});

  always_ff @(posedge clk_i) begin
    rot2_q <= $signed(rot2_r[63:0]);
    sat7_q <= sat6_q | rot2_r[64];
  end

  // clamp toward target, saturate to word width
  logic signed [63:0] tgt, clamp_d;
  logic signed [31:0] angle_d;
  logic               sat8_d;

  always_comb begin
    tgt = {{32{target_q[31]}}, target_q};
    if (target_q[31]) begin
      clamp_d = (rot2_q < tgt) ? tgt : rot2_q;
    end else begin
      clamp_d = (rot2_q > tgt) ? tgt : rot2_q;
    end
    sat8_d = sat7_q;
    if (clamp_d > 64'sd2147483647) begin
      angle_d = 32'sh7FFFFFFF;
      sat8_d  = 1'b1;
    end else if (clamp_d < -64'sd2147483648) begin
      angle_d = 32'sh80000000;
      sat8_d  = 1'b1;
    end else begin
      angle_d = clamp_d[31:0];
    end
  end

  logic signed [31:0] angle_q;
  logic               sat8_q;
  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    sat8_q  <= sat8_d;
  end

  assign done_o      = vld_q[LAT-1];
  assign angle_o     = angle_q;
  assign saturated_o = sat8_q;

  a_done_from_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT)
  ) else $error("result strobe without a matching command");

  a_brake_sign : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-3] && (b_q != 64'sd0)) |-> (b_q[63] == $past(accel_q[31]))
  ) else $error("braking term pushes against the acceleration");

endmodule
